// ----- src/wfts_pkg.sv -----
package wfts_pkg;

  localparam int TASK_SLOTS_DEF    = 64;
  localparam int VRUNTIME_BITS_DEF = 32;
  localparam int WEIGHT_BITS       = 17;

  localparam logic [7:0] LATENCY_RESET   = 8'd48;
  localparam logic [7:0] MIN_SLICE_RESET = 8'd6;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_SLEEPING = 3'd2,
    ST_RUNNABLE = 3'd3,
    ST_RUNNING  = 3'd4,
    ST_ZOMBIE   = 3'd5
  } task_st_t;

  typedef enum logic [2:0] {
    EV_TICK   = 3'd0,
    EV_CREATE = 3'd1,
    EV_SLEEP  = 3'd2,
    EV_WAKEUP = 3'd3,
    EV_KILL   = 3'd4,
    EV_NICE   = 3'd5,
    EV_EXIT   = 3'd6,
    EV_REAP   = 3'd7
  } ev_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_MODIFY,
    S_DSTART,
    S_DIV,
    S_APPLY,
    S_FINISH
  } fsm_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic CFG_LATENCY   = 1'b0;
  localparam logic CFG_MIN_SLICE = 1'b1;

  typedef struct packed {
    task_st_t          state;
    logic signed [5:0] nice;
    logic              killed;
    logic [15:0]       chan;
  } slot_meta_t;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_TABLE [40] = '{
    17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291,
    17'd29154, 17'd23254, 17'd18705, 17'd14949, 17'd11916,
    17'd9548,  17'd7620,  17'd6100,  17'd4904,  17'd3906,
    17'd3121,  17'd2501,  17'd1991,  17'd1586,  17'd1277,
    17'd1024,  17'd820,   17'd655,   17'd526,   17'd423,
    17'd335,   17'd272,   17'd215,   17'd172,   17'd137,
    17'd110,   17'd87,    17'd70,    17'd56,    17'd45,
    17'd36,    17'd29,    17'd23,    17'd18,    17'd15
  };

  function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic signed [5:0] n);
    logic [5:0] ix;
    if (n < -6'sd20) begin
      ix = 6'd0;
    end else if (n > 6'sd19) begin
      ix = 6'd39;
    end else begin
      ix = 6'(n + 6'sd20);
    end
    return WEIGHT_TABLE[ix];
  endfunction

endpackage

// ----- src/wfts_cell.sv -----
module wfts_cell #(
  parameter int IW       = 6,
  parameter int VB       = 32,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IW-1:0]       idx_in,
  input  logic [VB-1:0]       vr_in,
  input  wfts_pkg::slot_meta_t meta_in,
  output logic [IW-1:0]       idx_out,
  output logic [VB-1:0]       vr_out,
  output wfts_pkg::slot_meta_t meta_out
);

  logic [IW-1:0]        idx_r;
  logic [VB-1:0]        vr_r;
  wfts_pkg::slot_meta_t meta_r;

  // The ring advances every cycle; after reset cell i holds slot i.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= IW'(CELL_IDX);
      vr_r          <= '0;
      meta_r.state  <= (CELL_IDX == 0) ? wfts_pkg::ST_RUNNING : wfts_pkg::ST_UNUSED;
      meta_r.nice   <= '0;
      meta_r.killed <= 1'b0;
      meta_r.chan   <= '0;
    end else begin
      idx_r  <= idx_in;
      vr_r   <= vr_in;
      meta_r <= meta_in;
    end
  end

  assign idx_out  = idx_r;
  assign vr_out   = vr_r;
  assign meta_out = meta_r;

endmodule

// ----- src/wfts_div.sv -----
module wfts_div #(
  parameter int TW = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [7:0]                         lat,
  input  logic [wfts_pkg::WEIGHT_BITS-1:0]   w,
  input  logic [TW-1:0]                      den,
  output logic                               done,
  output logic [7:0]                         quo
);

  localparam int PW = 8 + wfts_pkg::WEIGHT_BITS;
  localparam int DW = TW + 8;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] den_r;
  logic [2:0]    k_r;
  logic          act_r, done_r;
  logic [7:0]    q_r, q_nxt;
  logic [PW-1:0] prod;
  logic [DW-1:0] shifted;

  assign prod    = PW'(lat) * PW'(w);
  assign shifted = DW'(den_r) << k_r;

  // The quotient never exceeds lat because w is part of den, so eight
  // restoring steps cover it.
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (rem_r >= shifted) begin
      rem_nxt = rem_r - shifted;
      q_nxt[k_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 3'd7;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        k_r   <= 3'd7;
      end else if (act_r) begin
        k_r <= k_r - 3'd1;
        if (k_r == 3'd0) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(prod);
      den_r <= den;
      q_r   <= '0;
    end else if (act_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- src/weighted_fair_task_scheduler.sv -----
// Channel  | Ports                                           | Flow
// input    | in_valid, in_stall, in_kind/slot/channel/nice_level | one event per beat
// result   | out_valid, out_stall, out_current_task ... created_slot | one result per event
// config   | cfg_we, cfg_index, cfg_wdata                     | write only, no wait
// The slot records rotate through a ring of TASK_SLOTS cells; all work on a slot
// happens as it passes the head, in whole passes over the table.
// A tick starts with the modify pass; every other event first takes an extra pass gathering
// the target slot. A rescheduling tick, create, sleep or wakeup then runs the slice divider
// when a slot is eligible, and an apply pass; a tick that counts the slice down takes an apply
// pass, and every other event, or a tick with no running slot, goes straight to the result.
// One event is handled at a time; a finished result waits in the output register
// while the next event is taken, and a result still stalled there holds the block.
// Reset is synchronous and loads slot 0 as running.
module weighted_fair_task_scheduler #(
  parameter int TASK_SLOTS    = wfts_pkg::TASK_SLOTS_DEF,
  parameter int VRUNTIME_BITS = wfts_pkg::VRUNTIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic [5:0]        in_slot,
  input  logic [15:0]       in_channel,
  input  logic signed [5:0] in_nice_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_current_task,
  output logic              out_task_running,
  output logic [7:0]        out_slice_remaining,
  output logic [1:0]        out_status,
  output logic [5:0]        out_created_slot,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int VB = VRUNTIME_BITS;
  localparam int WB = wfts_pkg::WEIGHT_BITS;
  localparam int TW = WB + $clog2(TASK_SLOTS + 1);
  localparam int SW = (IW > 6) ? IW : 6;
  localparam int AW = ((VB > TW) ? VB : TW) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

  // ring
  logic [IW-1:0]        c_idx  [TASK_SLOTS];
  logic [VB-1:0]        c_vr   [TASK_SLOTS];
  wfts_pkg::slot_meta_t c_meta [TASK_SLOTS];
  logic [IW-1:0]        h_idx;
  logic [VB-1:0]        h_vr, nx_vr;
  wfts_pkg::slot_meta_t h_meta, nx_meta;

  assign h_idx  = c_idx[TASK_SLOTS-1];
  assign h_vr   = c_vr[TASK_SLOTS-1];
  assign h_meta = c_meta[TASK_SLOTS-1];

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_ring
    if (i == 0) begin : g_head
      wfts_cell #(.IW(IW), .VB(VB), .CELL_IDX(i)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .idx_in(h_idx), .vr_in(nx_vr), .meta_in(nx_meta),
        .idx_out(c_idx[i]), .vr_out(c_vr[i]), .meta_out(c_meta[i])
      );
    end else begin : g_body
      wfts_cell #(.IW(IW), .VB(VB), .CELL_IDX(i)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .idx_in(c_idx[i-1]), .vr_in(c_vr[i-1]), .meta_in(c_meta[i-1]),
        .idx_out(c_idx[i]), .vr_out(c_vr[i]), .meta_out(c_meta[i])
      );
    end
  end

  // control and event registers
  wfts_pkg::fsm_t     fsm_r, fsm_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic [7:0]         lat_r, minsl_r;
  wfts_pkg::ev_kind_t kind_r, kind_nxt;
  logic [5:0]         slot_r, slot_nxt;
  logic [15:0]        chan_r, chan_nxt;
  logic signed [5:0]  nice_r, nice_nxt;
  logic [IW-1:0]      run_r, run_nxt;
  logic [7:0]         slice_r, slice_nxt;
  logic [1:0]         status_r, status_nxt;

  // gather pass
  wfts_pkg::task_st_t g_slot_st_r, g_slot_st_nxt;
  logic [VB-1:0]      g_par_vr_r, g_par_vr_nxt, g_cur_vr_r, g_cur_vr_nxt;
  logic               g_free_fnd_r, g_free_fnd_nxt;
  logic [IW-1:0]      g_free_idx_r, g_free_idx_nxt;

  // selection pass
  logic [TW-1:0]      e_tot_r, e_tot_nxt;
  logic               e_fnd_r, e_fnd_nxt, e_bcur_r, e_bcur_nxt;
  logic [IW-1:0]      e_best_r, e_best_nxt;
  logic [VB-1:0]      e_bvr_r, e_bvr_nxt;
  logic [WB-1:0]      e_bw_r, e_bw_nxt, e_own_r, e_own_nxt;
  wfts_pkg::task_st_t e_cur_st_r, e_cur_st_nxt;

  // apply pass
  logic               sched_r, sched_nxt, add_r, add_nxt, trun_r, trun_nxt;
  logic [TW-1:0]      d_r, d_nxt;

  // result
  logic               out_valid_r, out_valid_nxt;
  logic [5:0]         o_task_r, o_task_nxt, o_created_r, o_created_nxt;
  logic               o_run_r, o_run_nxt;
  logic [7:0]         o_slice_r, o_slice_nxt;
  logic [1:0]         o_status_r, o_status_nxt;

  logic               div_start, div_done;
  logic [7:0]         div_quo;

  wfts_div #(.TW(TW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .lat(lat_r), .w(e_bw_r), .den(e_tot_r),
    .done(div_done), .quo(div_quo)
  );

  logic [SW-1:0] h_idx_w, slot_w, run_w, free_w;
  logic          hit_slot, hit_cur, first, last, ok, accept;
  logic [WB-1:0] nw;
  logic          pool, elig, better, sd, used;
  logic [AW-1:0] vsum;
  logic [AW-1:0] vlim;

  assign h_idx_w  = SW'(h_idx);
  assign slot_w   = SW'(slot_r);
  assign run_w    = SW'(run_r);
  assign free_w   = SW'(g_free_idx_r);
  assign hit_slot = (h_idx_w == slot_w);
  assign hit_cur  = (h_idx == run_r);
  assign first    = (cnt_r == '0);
  assign last     = (cnt_r == LAST_IDX);
  assign ok       = (status_r == wfts_pkg::STAT_OK);
  assign in_stall = (fsm_r != wfts_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign vsum     = AW'(h_vr) + AW'(d_r);
  assign vlim     = AW'({VB{1'b1}});

  // Head of the ring: the record leaving the last cell is changed here.
  always_comb begin
    nx_vr   = h_vr;
    nx_meta = h_meta;
    if (fsm_r == wfts_pkg::S_MODIFY && ok) begin
      case (kind_r)
        wfts_pkg::EV_CREATE: begin
          if (h_idx == g_free_idx_r) begin
            nx_meta.state  = wfts_pkg::ST_RUNNABLE;
            nx_meta.nice   = '0;
            nx_meta.killed = 1'b0;
            nx_meta.chan   = '0;
            nx_vr          = g_par_vr_r;
          end
        end
        wfts_pkg::EV_SLEEP: begin
          if (hit_slot) begin
            nx_meta.chan  = chan_r;
            nx_meta.state = wfts_pkg::ST_SLEEPING;
          end
        end
        wfts_pkg::EV_WAKEUP: begin
          if (h_meta.state == wfts_pkg::ST_SLEEPING && h_meta.chan == chan_r) begin
            nx_meta.state = wfts_pkg::ST_RUNNABLE;
            nx_vr         = g_cur_vr_r;
          end
        end
        wfts_pkg::EV_KILL: begin
          if (hit_slot) begin
            nx_meta.killed = 1'b1;
            if (h_meta.state == wfts_pkg::ST_SLEEPING) begin
              nx_meta.state = wfts_pkg::ST_RUNNABLE;
            end
          end
        end
        wfts_pkg::EV_NICE: begin
          if (hit_slot) begin
            nx_meta.nice = nice_r;
          end
        end
        wfts_pkg::EV_EXIT: begin
          if (hit_slot) begin
            nx_meta.state = wfts_pkg::ST_ZOMBIE;
          end
        end
        wfts_pkg::EV_REAP: begin
          if (hit_slot) begin
            nx_meta.state  = wfts_pkg::ST_UNUSED;
            nx_meta.nice   = '0;
            nx_meta.killed = 1'b0;
            nx_meta.chan   = '0;
            nx_vr          = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (fsm_r == wfts_pkg::S_APPLY) begin
      if (sched_r) begin
        // Demote the old current slot first, so a re-elected slot ends running.
        if (hit_cur && h_meta.state == wfts_pkg::ST_RUNNING) begin
          nx_meta.state = wfts_pkg::ST_RUNNABLE;
        end
        if (e_fnd_r && h_idx == e_best_r) begin
          nx_meta.state = wfts_pkg::ST_RUNNING;
        end
      end
      if (add_r && hit_cur) begin
        nx_vr = (vsum > vlim) ? {VB{1'b1}} : vsum[VB-1:0];
      end
    end
  end

  // Gather and selection accumulators.
  always_comb begin
    g_slot_st_nxt  = first ? wfts_pkg::ST_UNUSED : g_slot_st_r;
    g_par_vr_nxt   = first ? '0 : g_par_vr_r;
    g_cur_vr_nxt   = first ? '0 : g_cur_vr_r;
    g_free_fnd_nxt = first ? 1'b0 : g_free_fnd_r;
    g_free_idx_nxt = first ? '0 : g_free_idx_r;
    if (hit_slot) begin
      g_slot_st_nxt = h_meta.state;
      g_par_vr_nxt  = h_vr;
    end
    if (hit_cur) begin
      g_cur_vr_nxt = h_vr;
    end
    if (h_meta.state == wfts_pkg::ST_UNUSED && (!g_free_fnd_nxt || h_idx < g_free_idx_nxt)) begin
      g_free_fnd_nxt = 1'b1;
      g_free_idx_nxt = h_idx;
    end

    e_tot_nxt    = first ? '0 : e_tot_r;
    e_fnd_nxt    = first ? 1'b0 : e_fnd_r;
    e_bcur_nxt   = first ? 1'b0 : e_bcur_r;
    e_best_nxt   = first ? '0 : e_best_r;
    e_bvr_nxt    = first ? '0 : e_bvr_r;
    e_bw_nxt     = first ? '0 : e_bw_r;
    e_own_nxt    = first ? '0 : e_own_r;
    e_cur_st_nxt = first ? wfts_pkg::ST_UNUSED : e_cur_st_r;
    nw   = wfts_pkg::weight_of(nx_meta.nice);
    pool = (nx_meta.state == wfts_pkg::ST_RUNNABLE || nx_meta.state == wfts_pkg::ST_RUNNING)
           && !nx_meta.killed;
    elig = (nx_meta.state == wfts_pkg::ST_RUNNABLE ||
            (hit_cur && nx_meta.state == wfts_pkg::ST_RUNNING)) && !nx_meta.killed;
    // On a tie the current slot is kept, otherwise the lower index wins.
    better = !e_fnd_nxt || nx_vr < e_bvr_nxt ||
             (nx_vr == e_bvr_nxt && (hit_cur || (!e_bcur_nxt && h_idx < e_best_nxt)));
    if (pool) begin
      e_tot_nxt = e_tot_nxt + TW'(nw);
    end
    if (elig && better) begin
      e_fnd_nxt  = 1'b1;
      e_bcur_nxt = hit_cur;
      e_best_nxt = h_idx;
      e_bvr_nxt  = nx_vr;
      e_bw_nxt   = nw;
    end
    if (hit_cur) begin
      e_cur_st_nxt = nx_meta.state;
      e_own_nxt    = nw;
    end
  end

  // Sequencer.
  always_comb begin
    fsm_nxt       = fsm_r;
    cnt_nxt       = cnt_r + IW'(1);
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    chan_nxt      = chan_r;
    nice_nxt      = nice_r;
    run_nxt       = run_r;
    slice_nxt     = slice_r;
    status_nxt    = status_r;
    sched_nxt     = sched_r;
    add_nxt       = add_r;
    trun_nxt      = trun_r;
    d_nxt         = d_r;
    div_start     = 1'b0;
    used          = (g_slot_st_nxt != wfts_pkg::ST_UNUSED);
    sd            = 1'b0;
    out_valid_nxt = out_valid_r;
    o_task_nxt    = o_task_r;
    o_run_nxt     = o_run_r;
    o_slice_nxt   = o_slice_r;
    o_status_nxt  = o_status_r;
    o_created_nxt = o_created_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (fsm_r)
      wfts_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          kind_nxt   = wfts_pkg::ev_kind_t'(in_kind);
          slot_nxt   = in_slot;
          chan_nxt   = in_channel;
          nice_nxt   = in_nice_level;
          status_nxt = wfts_pkg::STAT_OK;
          sched_nxt  = 1'b0;
          add_nxt    = 1'b0;
          fsm_nxt    = (wfts_pkg::ev_kind_t'(in_kind) == wfts_pkg::EV_TICK) ?
                       wfts_pkg::S_MODIFY : wfts_pkg::S_GATHER;
        end
      end
      wfts_pkg::S_GATHER: begin
        if (last) begin
          cnt_nxt = '0;
          fsm_nxt = wfts_pkg::S_MODIFY;
          case (kind_r)
            wfts_pkg::EV_CREATE: begin
              if (!used) status_nxt = wfts_pkg::STAT_BAD;
              else if (!g_free_fnd_nxt) status_nxt = wfts_pkg::STAT_FULL;
            end
            wfts_pkg::EV_SLEEP, wfts_pkg::EV_KILL: begin
              if (!used) status_nxt = wfts_pkg::STAT_BAD;
            end
            wfts_pkg::EV_NICE: begin
              if (!used || nice_r < -6'sd20 || nice_r > 6'sd19) begin
                status_nxt = wfts_pkg::STAT_BAD;
              end
            end
            wfts_pkg::EV_EXIT: begin
              if (!used || slot_r == '0) status_nxt = wfts_pkg::STAT_BAD;
            end
            wfts_pkg::EV_REAP: begin
              if (g_slot_st_nxt != wfts_pkg::ST_ZOMBIE) status_nxt = wfts_pkg::STAT_BAD;
            end
            default: begin
            end
          endcase
          if (status_nxt == wfts_pkg::STAT_OK && kind_r inside
              {wfts_pkg::EV_CREATE, wfts_pkg::EV_SLEEP, wfts_pkg::EV_WAKEUP,
               wfts_pkg::EV_EXIT}) begin
            slice_nxt = '0;
          end
        end
      end
      wfts_pkg::S_MODIFY: begin
        if (last) begin
          cnt_nxt = '0;
          sd = ok && (slice_r <= 8'd1) && kind_r inside
               {wfts_pkg::EV_TICK, wfts_pkg::EV_CREATE, wfts_pkg::EV_SLEEP,
                wfts_pkg::EV_WAKEUP};
          if (sd) begin
            sched_nxt = 1'b1;
            trun_nxt  = e_fnd_nxt;
            fsm_nxt   = e_fnd_nxt ? wfts_pkg::S_DSTART : wfts_pkg::S_APPLY;
          end else if (kind_r == wfts_pkg::EV_TICK &&
                       e_cur_st_nxt == wfts_pkg::ST_RUNNING) begin
            add_nxt   = 1'b1;
            trun_nxt  = 1'b1;
            slice_nxt = slice_r - 8'd1;
            d_nxt     = (e_tot_nxt > TW'(e_own_nxt)) ? e_tot_nxt - TW'(e_own_nxt) : '0;
            fsm_nxt   = wfts_pkg::S_APPLY;
          end else begin
            trun_nxt = (e_cur_st_nxt == wfts_pkg::ST_RUNNING);
            fsm_nxt  = wfts_pkg::S_FINISH;
          end
        end
      end
      wfts_pkg::S_DSTART: begin
        div_start = 1'b1;
        fsm_nxt   = wfts_pkg::S_DIV;
      end
      wfts_pkg::S_DIV: begin
        cnt_nxt = '0;
        if (div_done) begin
          slice_nxt = (div_quo < minsl_r) ? minsl_r : div_quo;
          fsm_nxt   = wfts_pkg::S_APPLY;
        end
      end
      wfts_pkg::S_APPLY: begin
        if (last) begin
          if (sched_r && e_fnd_r) begin
            run_nxt = e_best_r;
          end
          fsm_nxt = wfts_pkg::S_FINISH;
        end
      end
      wfts_pkg::S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_task_nxt    = run_w[5:0];
          o_run_nxt     = trun_r;
          o_slice_nxt   = slice_r;
          o_status_nxt  = status_r;
          o_created_nxt = (kind_r == wfts_pkg::EV_CREATE && ok) ? free_w[5:0] : 6'd0;
          fsm_nxt       = wfts_pkg::S_IDLE;
        end
      end
      default: begin
        fsm_nxt = wfts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= wfts_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      run_r       <= '0;
      slice_r     <= '0;
    end else begin
      fsm_r       <= fsm_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
      slice_r     <= slice_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r   <= wfts_pkg::LATENCY_RESET;
      minsl_r <= wfts_pkg::MIN_SLICE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wfts_pkg::CFG_LATENCY:   lat_r   <= cfg_wdata;
        wfts_pkg::CFG_MIN_SLICE: minsl_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    chan_r     <= chan_nxt;
    nice_r     <= nice_nxt;
    status_r   <= status_nxt;
    sched_r    <= sched_nxt;
    add_r      <= add_nxt;
    trun_r     <= trun_nxt;
    d_r        <= d_nxt;
    o_task_r    <= o_task_nxt;
    o_run_r     <= o_run_nxt;
    o_slice_r   <= o_slice_nxt;
    o_status_r  <= o_status_nxt;
    o_created_r <= o_created_nxt;
    if (fsm_r == wfts_pkg::S_GATHER) begin
      g_slot_st_r  <= g_slot_st_nxt;
      g_par_vr_r   <= g_par_vr_nxt;
      g_cur_vr_r   <= g_cur_vr_nxt;
      g_free_fnd_r <= g_free_fnd_nxt;
      g_free_idx_r <= g_free_idx_nxt;
    end
    if (fsm_r == wfts_pkg::S_MODIFY) begin
      e_tot_r    <= e_tot_nxt;
      e_fnd_r    <= e_fnd_nxt;
      e_bcur_r   <= e_bcur_nxt;
      e_best_r   <= e_best_nxt;
      e_bvr_r    <= e_bvr_nxt;
      e_bw_r     <= e_bw_nxt;
      e_own_r    <= e_own_nxt;
      e_cur_st_r <= e_cur_st_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_current_task    = o_task_r;
  assign out_task_running    = o_run_r;
  assign out_slice_remaining = o_slice_r;
  assign out_status          = o_status_r;
  assign out_created_slot    = o_created_r;

endmodule

// ----- src/wfts_checker.sv -----
module wfts_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        in_kind,
  input logic [5:0]        in_slot,
  input logic [15:0]       in_channel,
  input logic signed [5:0] in_nice_level,
  input logic              out_valid,
  input logic              out_stall,
  input logic [5:0]        out_current_task,
  input logic              out_task_running,
  input logic [7:0]        out_slice_remaining,
  input logic [1:0]        out_status,
  input logic [5:0]        out_created_slot,
  input logic              cfg_we,
  input logic [0:0]        cfg_index,
  input logic [7:0]        cfg_wdata
);

  // An accepted event keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken right after an accepted event");

  // A new result only appears while an event was in progress.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no event in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == wfts_pkg::STAT_OK || out_status == wfts_pkg::STAT_BAD ||
                   out_status == wfts_pkg::STAT_FULL))
    else $error("status code out of range");

  // A failed event never reports a created slot.
  a_created_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != wfts_pkg::STAT_OK |-> out_created_slot == 6'd0)
    else $error("created slot reported on a failed event");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_current_task))
    else $error("stalled result dropped or changed");

endmodule

bind weighted_fair_task_scheduler wfts_checker u_wfts_checker (.*);
